>>> hdl/ohlcv_pkg.sv
`timescale 1ns / 1ps
package ohlcv_pkg;
  localparam int NUM_SYMBOLS = 64;
  localparam int SLOT_W = 6;
  localparam int IV_W = 47;
  localparam int TS_W = 63;
  localparam int VOL_W = 48;
  localparam int CNT_W = 32;
  localparam int QTY_W = 32;
  localparam int DIV_STEPS = TS_W;
  localparam int STEP_W = 6;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic [63:0]      open_p;
    logic [63:0]      high_p;
    logic [63:0]      low_p;
    logic [63:0]      close_p;
    logic [VOL_W-1:0] volume;
    logic [CNT_W-1:0] ticks;
    logic [TS_W-1:0]  start_t;
    logic [TS_W-1:0]  end_t;
  } bar_t;

  typedef struct packed {
    logic [SLOT_W-1:0] symbol;
    bar_t              bar;
    logic              last;
  } bar_out_t;

  typedef struct packed {
    logic                command;
    logic [SLOT_W-1:0]   symbol_index;
    logic signed [63:0]  price;
    logic [QTY_W-1:0]    quantity;
    logic [TS_W-1:0]     timestamp;
  } tick_in_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_READ, ST_TICK, ST_FLUSH_RD, ST_FLUSH_CHK, ST_OUT
  } state_t;
endpackage

>>> hdl/ohlcv_if.sv
`timescale 1ns / 1ps
interface ohlcv_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ohlcv_div.sv
`timescale 1ns / 1ps
module ohlcv_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ohlcv_pkg::TS_W-1:0] ts,
  input  logic [ohlcv_pkg::IV_W-1:0] iv,
  output logic                     done,
  output logic [ohlcv_pkg::TS_W-1:0] aligned
);
  import ohlcv_pkg::*;
  // restoring division, one quotient bit a cycle; aligned = ts - remainder
  logic [TS_W-1:0] dividend, ts_hold;
  logic [IV_W:0]   rem;
  logic [IV_W-1:0] div_iv;
  logic [STEP_W-1:0] step;
  logic busy;
  logic [IV_W+1:0] trial;

  assign trial = {rem, dividend[TS_W-1]} - {2'b00, div_iv};
  assign aligned = ts_hold - TS_W'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DIV_STEPS - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= ts;
      ts_hold  <= ts;
      rem      <= '0;
      div_iv   <= (iv == '0) ? IV_W'(1) : iv;
    end else if (busy) begin
      dividend <= {dividend[TS_W-2:0], 1'b0};
      if (!trial[IV_W+1]) rem <= trial[IV_W:0];
      else rem <= {rem[IV_W-1:0], dividend[TS_W-1]};
    end
  end
endmodule

>>> hdl/ohlcv_slot_ram.sv
`timescale 1ns / 1ps
module ohlcv_slot_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ohlcv_pkg::SLOT_W-1:0] waddr,
  input  ohlcv_pkg::bar_t              wdata,
  input  logic [ohlcv_pkg::SLOT_W-1:0] raddr,
  output ohlcv_pkg::bar_t              rdata
);
  import ohlcv_pkg::*;
  bar_t mem [NUM_SYMBOLS];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/ohlcv_bar_aggregator_core.sv
`timescale 1ns / 1ps
// OHLCV bar aggregator: one bar per symbol slot, held in a slot RAM.
// Tick: a restoring divider aligns the timestamp, then one RAM read
//   and one write back; a finished bar is loaded into the output register at the write back.
// One item at a time: a new beat is taken only in idle, once the last item is through.
// Flush: read and check states for each of the 64 slots, then the output state.
// Synchronous active-high rst clears the active bits and sets the interval to 60 s.
module ohlcv_bar_aggregator_core (
  input  logic clk,
  input  logic rst,
  ohlcv_if.sink   in_ch,
  ohlcv_if.source out_ch,
  input  logic                         cfg_we,
  input  logic [ohlcv_pkg::IV_W-1:0]   cfg_wdata
);
  import ohlcv_pkg::*;

  state_t state, state_next;
  logic [IV_W-1:0] interval_ns;
  logic [NUM_SYMBOLS-1:0] active;
  tick_in_t item;
  logic [SLOT_W-1:0] scan;
  bar_out_t out_reg;
  logic out_valid;

  logic div_start, div_done;
  logic [TS_W-1:0] aligned, aligned_q;
  logic ram_we;
  logic [SLOT_W-1:0] raddr;
  bar_t wbar, rbar;
  tick_in_t in_beat;
  logic in_fire;
  bar_t fresh, upd;
  logic [VOL_W:0] vsum;
  logic is_active, roll;
  logic last_scan, more_active;
  logic [NUM_SYMBOLS-1:0] above_mask;

  assign in_beat = tick_in_t'(in_ch.data);
  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_reg;

  ohlcv_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .ts(in_beat.timestamp),
    .iv(interval_ns), .done(div_done), .aligned(aligned)
  );

  ohlcv_slot_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(item.symbol_index), .wdata(wbar),
    .raddr(raddr), .rdata(rbar)
  );

  assign div_start = in_fire && (in_beat.command == CMD_TICK);
  assign raddr = (state == ST_FLUSH_RD || state == ST_FLUSH_CHK) ? scan : item.symbol_index;

  // new bar from the held tick
  always_comb begin
    fresh.open_p  = item.price;
    fresh.high_p  = item.price;
    fresh.low_p   = item.price;
    fresh.close_p = item.price;
    fresh.volume  = VOL_W'(item.quantity);
    fresh.ticks   = CNT_W'(1);
    fresh.start_t = aligned_q;
    fresh.end_t   = item.timestamp;
  end
  always_ff @(posedge clk) if (div_done) aligned_q <= aligned;

  assign vsum = {1'b0, rbar.volume} + (VOL_W+1)'(item.quantity);
  always_comb begin
    upd = rbar;
    if (item.price > $signed(rbar.high_p)) upd.high_p = item.price;
    if ($signed(rbar.low_p) > item.price) upd.low_p = item.price;
    upd.close_p = item.price;
    upd.volume = vsum[VOL_W] ? {VOL_W{1'b1}} : vsum[VOL_W-1:0];
    if (rbar.ticks != {CNT_W{1'b1}}) upd.ticks = rbar.ticks + 1'b1;
    upd.end_t = item.timestamp;
  end

  assign is_active = active[item.symbol_index];
  assign roll = is_active && (rbar.start_t != aligned_q);
  assign ram_we = (state == ST_TICK);
  assign wbar = (!is_active || roll) ? fresh : upd;

  // flush scan: a bar is the last of the run when no active slot lies above it
  assign last_scan = (scan == SLOT_W'(NUM_SYMBOLS - 1));
  assign above_mask = ({NUM_SYMBOLS{1'b1}} << scan) << 1;
  assign more_active = |(active & above_mask);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = (in_beat.command == CMD_FLUSH) ? ST_FLUSH_RD : ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_READ;
      ST_READ: state_next = ST_TICK;
      ST_TICK: state_next = roll ? ST_OUT : ST_IDLE;
      ST_FLUSH_RD: state_next = ST_FLUSH_CHK;
      ST_FLUSH_CHK: begin
        if (out_valid && active[scan]) state_next = ST_FLUSH_CHK;
        else if (last_scan) state_next = ST_OUT;
        else state_next = ST_FLUSH_RD;
      end
      // drain the output register before the next beat
      ST_OUT: if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // flush output: an active bar is loaded once the previous bar has gone;
  // the scan holds on that slot meanwhile, the RAM read staying on it
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      interval_ns <= IV_W'(64'd60000000000);
      active <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) interval_ns <= cfg_wdata;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (in_fire) begin
        item <= in_beat;
        scan <= '0;
      end
      if (state == ST_TICK) begin
        active[item.symbol_index] <= 1'b1;
        if (roll) begin
          out_reg <= '{symbol: item.symbol_index, bar: rbar, last: 1'b1};
          out_valid <= 1'b1;
        end
      end
      if (state == ST_FLUSH_CHK && !(out_valid && active[scan])) begin
        if (active[scan]) begin
          active[scan] <= 1'b0;
          out_reg <= '{symbol: scan, bar: rbar, last: !more_active};
          out_valid <= 1'b1;
        end
        if (!last_scan) scan <= scan + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_fire |=> !in_ch.ready);
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK) |=> active[$past(item.symbol_index)]);
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> out_valid && $stable(out_reg));
endmodule

>>> verif/ohlcv_bar_aggregator_core_tb.sv
`timescale 1ns / 1ps
module ohlcv_bar_aggregator_core_tb;
  import ohlcv_pkg::*;

  // Per-slot OHLCV bar state, kept in step with every accepted beat.
  class bar_book;
    logic [IV_W-1:0] interval;
    bit              active [NUM_SYMBOLS];
    bar_t            bars [NUM_SYMBOLS];
    bar_out_t        due [$];
    int              errors;

    function new();
      interval = 47'd60000000000;
      errors = 0;
      foreach (active[i]) active[i] = 1'b0;
    endfunction

    function void start_bar(int s, tick_in_t t, logic [TS_W-1:0] st);
      bars[s].open_p = t.price;
      bars[s].high_p = t.price;
      bars[s].low_p = t.price;
      bars[s].close_p = t.price;
      bars[s].volume = VOL_W'(t.quantity);
      bars[s].ticks = 1;
      bars[s].start_t = st;
      bars[s].end_t = t.timestamp;
      active[s] = 1'b1;
    endfunction

    function void note_input(tick_in_t t);
      bar_out_t r;
      logic [TS_W-1:0] iv, st;
      logic [VOL_W:0] vsum;
      int s, last;
      if (t.command == CMD_FLUSH) begin
        last = -1;
        for (s = 0; s < NUM_SYMBOLS; s++) begin
          if (active[s]) begin
            r.symbol = SLOT_W'(s);
            r.bar = bars[s];
            r.last = 1'b0;
            due.push_back(r);
            last = due.size() - 1;
            active[s] = 1'b0;
          end
        end
        if (last >= 0) due[last].last = 1'b1;
        return;
      end
      s = t.symbol_index;
      iv = (interval == 0) ? TS_W'(1) : TS_W'(interval);
      st = (t.timestamp / iv) * iv;
      if (!active[s]) begin
        start_bar(s, t, st);
      end else if (st != bars[s].start_t) begin
        r.symbol = SLOT_W'(s);
        r.bar = bars[s];
        r.last = 1'b1;
        due.push_back(r);
        start_bar(s, t, st);
      end else begin
        if ($signed(t.price) > $signed(bars[s].high_p)) bars[s].high_p = t.price;
        if ($signed(t.price) < $signed(bars[s].low_p)) bars[s].low_p = t.price;
        bars[s].close_p = t.price;
        vsum = {1'b0, bars[s].volume} + (VOL_W+1)'(t.quantity);
        bars[s].volume = vsum[VOL_W] ? {VOL_W{1'b1}} : vsum[VOL_W-1:0];
        if (bars[s].ticks != {CNT_W{1'b1}}) bars[s].ticks++;
        bars[s].end_t = t.timestamp;
      end
    endfunction

    function void check_bar(bar_out_t got);
      bar_out_t e;
      if (due.size() == 0) begin
        $error("bar with nothing expected: symbol %0d", got.symbol);
        errors++;
        return;
      end
      e = due.pop_front();
      if (got.symbol !== e.symbol) begin
        $error("bar_symbol exp %0d got %0d", e.symbol, got.symbol); errors++;
      end
      if (got.bar.open_p !== e.bar.open_p) begin
        $error("open_price exp %0d got %0d", $signed(e.bar.open_p),
               $signed(got.bar.open_p)); errors++;
      end
      if (got.bar.high_p !== e.bar.high_p) begin
        $error("high_price exp %0d got %0d", $signed(e.bar.high_p),
               $signed(got.bar.high_p)); errors++;
      end
      if (got.bar.low_p !== e.bar.low_p) begin
        $error("low_price exp %0d got %0d", $signed(e.bar.low_p),
               $signed(got.bar.low_p)); errors++;
      end
      if (got.bar.close_p !== e.bar.close_p) begin
        $error("close_price exp %0d got %0d", $signed(e.bar.close_p),
               $signed(got.bar.close_p)); errors++;
      end
      if (got.bar.volume !== e.bar.volume) begin
        $error("bar_volume exp %0d got %0d", e.bar.volume, got.bar.volume); errors++;
      end
      if (got.bar.ticks !== e.bar.ticks) begin
        $error("bar_ticks exp %0d got %0d", e.bar.ticks, got.bar.ticks); errors++;
      end
      if (got.bar.start_t !== e.bar.start_t) begin
        $error("bar start_t exp %0d got %0d", e.bar.start_t, got.bar.start_t); errors++;
      end
      if (got.bar.end_t !== e.bar.end_t) begin
        $error("bar end_t exp %0d got %0d", e.bar.end_t, got.bar.end_t); errors++;
      end
      if (got.last !== e.last) begin
        $error("last_of_run exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IV_W-1:0] cfg_wdata;
  bit quiet;                       // no idling on either side this phase
  bar_book book;

  ohlcv_if #(.W($bits(tick_in_t))) in_ch ();
  ohlcv_if #(.W($bits(bar_out_t))) out_ch ();

  ohlcv_bar_aggregator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous cap: ends a hung run and reports failure.
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // Beat monitor: note inputs before results, a result never stems from
  // the beat accepted on the same edge.
  always @(posedge clk) begin
    if (!rst && book != null) begin
      if (in_ch.valid && in_ch.ready) book.note_input(tick_in_t'(in_ch.data));
      if (out_ch.valid && out_ch.ready) book.check_bar(bar_out_t'(out_ch.data));
    end
  end

  // Result side: random stall before each bar, held ready until a beat moves.
  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      g = quiet ? 0 : $urandom_range(0, 10);
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_beat(tick_in_t t);
    int g;
    g = quiet ? 0 : $urandom_range(0, 10);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= t;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic tick(int s, logic [63:0] p, logic [31:0] q, logic [TS_W-1:0] ts);
    tick_in_t t;
    t.command = CMD_TICK;
    t.symbol_index = SLOT_W'(s);
    t.price = p;
    t.quantity = q;
    t.timestamp = ts;
    send_beat(t);
  endtask

  // Flush carries random junk in the ignored fields.
  task automatic flush_all();
    tick_in_t t;
    t = ($bits(tick_in_t))'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    t.command = CMD_FLUSH;
    send_beat(t);
  endtask

  // Drain, let a tick or a whole flush scan finish, then write the interval.
  task automatic set_interval(logic [IV_W-1:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (book.due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.interval = v;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Mostly ticks on a few slots around one base time, so bars grow and roll.
  task automatic random_phase(int n);
    logic [TS_W-1:0] base, iv;
    int k;
    iv = (book.interval == 0) ? TS_W'(1) : TS_W'(book.interval);
    base = TS_W'(rnd64()) >> $urandom_range(0, 3);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        flush_all();
      end else if ($urandom_range(0, 7) == 0) begin
        tick($urandom_range(0, 63), rnd64(), $urandom, TS_W'(rnd64()));
      end else begin
        tick($urandom_range(0, 5), rnd64() >>> $urandom_range(0, 60), $urandom,
             base + iv * TS_W'($urandom_range(0, 2)) + TS_W'(rnd64() % iv));
      end
    end
    flush_all();
  endtask

  localparam logic [63:0] PMAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] PMIN = 64'h8000_0000_0000_0000;
  localparam logic [TS_W-1:0] TMAX = {TS_W{1'b1}};

  initial begin
    book = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    quiet = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset interval (60 s)
    tick(0, PMAX, 32'hffff_ffff, TMAX);
    tick(0, PMIN, 32'hffff_ffff, TMAX - 5);     // same bar: new low, volume adds
    tick(0, 64'd0, 32'd0, TMAX - 1);            // close only
    tick(63, 64'd1, 32'd7, 63'd0);
    tick(5, -64'sd10, 32'd3, 63'd59_999_999_999);
    tick(5, 64'd20, 32'd4, 63'd60_000_000_000); // next interval: emits bar
    flush_all();                                // several bars, last marked
    flush_all();                                // nothing active: no result

    // zero interval: start equals timestamp
    set_interval('0);
    tick(1, 64'd5, 32'd1, 63'd1000);
    tick(1, 64'd9, 32'd1, 63'd1000);
    tick(1, 64'd2, 32'd1, 63'd1001);
    flush_all();

    set_interval(IV_W'(1));
    quiet = 1'b1;
    random_phase(21);
    quiet = 1'b0;
    set_interval({IV_W{1'b1}});
    random_phase(21);
    set_interval(IV_W'(64'd86400000000000));
    random_phase(21);
    set_interval(IV_W'($urandom_range(1, 5000)));
    random_phase(21);
    set_interval(IV_W'(rnd64()));
    random_phase(21);

    in_ch.valid <= 1'b0;
    while (book.due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (book.errors == 0 && book.due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

>>> filelist.f
hdl/ohlcv_pkg.sv
hdl/ohlcv_if.sv
hdl/ohlcv_div.sv
hdl/ohlcv_slot_ram.sv
hdl/ohlcv_bar_aggregator_core.sv
verif/ohlcv_bar_aggregator_core_tb.sv
